// ===== hw/rtl/fps_pkg.sv =====
// Shared types, sizing and codes for the FCFS process scheduler.
// Used by fps_pick, fcfs_process_scheduler and the testbench; depends on nothing.
`default_nettype none

package fps_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);

  // Item kinds on the action field.
  localparam logic ACT_ADMIT = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // Report status codes.
  localparam logic [2:0] ST_ADMITTED = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_RAN      = 3'd2;
  localparam logic [2:0] ST_FINISHED = 3'd3;
  localparam logic [2:0] ST_IDLE     = 3'd4;

  // One process table entry as held in the slot RAM.
  typedef struct packed {
    logic [7:0]  pid;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Compare slot fed to the pick unit, one RAM word behind the read address.
  typedef struct packed {
    logic             live;
    logic [IDX_W-1:0] idx;
    logic             slot_ok;
  } scan_t;

  // Best candidate found so far in the current scan.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } pick_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module fps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fps_pick.sv =====
// Earliest-arrival pick unit: one comparator walked over the slot RAM words.
// Depends on fps_pkg.
`default_nettype none

module fps_pick (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 clr,
  input  wire fps_pkg::scan_t       cmp,
  input  wire fps_pkg::entry_t      rd,
  input  wire logic [15:0]          now,
  output fps_pkg::pick_t            pick
);

  logic take;

  // Strict less-than keeps the lower slot on equal arrival.
  assign take = cmp.live && cmp.slot_ok && (rd.arrival <= now) &&
                (!pick.found || (rd.arrival < pick.entry.arrival));

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      pick.found <= 1'b0;
    end else if (take) begin
      pick.found <= 1'b1;
      pick.idx   <= cmp.idx;
      pick.entry <= rd;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fcfs_process_scheduler.sv =====
// FCFS process scheduler top level. Slot payloads live in fps_ram, valid
// bits and totals in flops; the pick runs in fps_pick. Depends on fps_pkg.
`default_nettype none

// One item is worked at a time; a finished result sits in the output
// register so the next word can be taken while it waits. A tick reads every
// slot word once through the single read port of the slot RAM and checks
// it with one comparator, then the calc state computes turnaround and
// waiting and the done state writes back and loads the result.
// After reset the block is ready at once; the slot RAM needs no clearing.
module fcfs_process_scheduler (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        action,
  input  wire logic [7:0]  process_id,
  input  wire logic [15:0] arrival,
  input  wire logic [15:0] burst_time,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [7:0]       running_id,
  output logic [15:0]      tick_time,
  output logic [15:0]      turnaround,
  output logic [15:0]      waiting,
  output logic [31:0]      sum_turnaround,
  output logic [31:0]      sum_waiting
);

  localparam int CNT_W = $clog2(fps_pkg::SLOTS + 1);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(fps_pkg::SLOTS);
  localparam logic [fps_pkg::IDX_W-1:0] LAST_IDX = fps_pkg::IDX_W'(fps_pkg::SLOTS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADMIT = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_CALC  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                  state;
  logic [2:0]                  state_next;
  logic [fps_pkg::SLOTS-1:0]   slot_valid;
  logic [15:0]                 current_time;
  logic [31:0]                 total_turnaround;
  logic [31:0]                 total_waiting;

  logic [7:0]                  req_pid;
  logic [15:0]                 req_arr;
  logic [15:0]                 req_burst;

  logic [CNT_W-1:0]            scan_cnt;
  logic                        cmp_live;
  logic [fps_pkg::IDX_W-1:0]   cmp_idx;
  fps_pkg::scan_t              cmp;
  fps_pkg::pick_t              pick;
  fps_pkg::entry_t             rd_entry;
  fps_pkg::entry_t             wr_entry;

  logic [2:0]                  calc_status;
  logic [15:0]                 calc_tt;
  logic [15:0]                 calc_wt;

  logic                        accept;
  logic                        out_free;
  logic                        free_found;
  logic [fps_pkg::IDX_W-1:0]   free_idx;
  logic                        ram_we;
  logic [fps_pkg::IDX_W-1:0]   ram_waddr;
  logic [16:0]                 tt_diff;
  logic [15:0]                 tt_sat;
  logic [32:0]                 sum_tt;
  logic [32:0]                 sum_wt;
  logic [31:0]                 tot_tt_next;
  logic [31:0]                 tot_wt_next;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = fps_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = fps_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (action == fps_pkg::ACT_ADMIT) ? S_ADMIT : S_SCAN;
        end
      end
      S_ADMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (cmp_live && (cmp_idx == LAST_IDX)) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_pid   <= process_id;
      req_arr   <= arrival;
      req_burst <= burst_time;
    end
  end

  // Scan: read address leads the compare by the RAM latency.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      cmp_live <= 1'b0;
    end else begin
      cmp_live <= (state == S_SCAN) && (scan_cnt < SCAN_END);
      if (accept) begin
        scan_cnt <= '0;
      end else if ((state == S_SCAN) && (scan_cnt < SCAN_END)) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_cnt[fps_pkg::IDX_W-1:0];
  end

  assign cmp.live    = cmp_live;
  assign cmp.idx     = cmp_idx;
  assign cmp.slot_ok = slot_valid[cmp_idx];

  fps_pick u_pick (
    .clk  (clk),
    .rst  (rst),
    .clr  (accept),
    .cmp  (cmp),
    .rd   (rd_entry),
    .now  (current_time),
    .pick (pick)
  );

  // Turnaround and waiting for a finishing process.
  assign tt_diff = ({1'b0, current_time} + 17'd1) - {1'b0, pick.entry.arrival};
  assign tt_sat  = tt_diff[16] ? 16'hFFFF : tt_diff[15:0];

  always_ff @(posedge clk) begin
    if (state == S_CALC) begin
      calc_tt <= '0;
      calc_wt <= '0;
      if (!pick.found) begin
        calc_status <= fps_pkg::ST_IDLE;
      end else if (pick.entry.remaining <= 16'd1) begin
        calc_status <= fps_pkg::ST_FINISHED;
        calc_tt     <= tt_sat;
        calc_wt     <= (tt_sat >= pick.entry.burst) ? (tt_sat - pick.entry.burst) : 16'd0;
      end else begin
        calc_status <= fps_pkg::ST_RAN;
      end
    end
  end

  assign sum_tt      = {1'b0, total_turnaround} + {17'd0, calc_tt};
  assign sum_wt      = {1'b0, total_waiting} + {17'd0, calc_wt};
  assign tot_tt_next = sum_tt[32] ? 32'hFFFF_FFFF : sum_tt[31:0];
  assign tot_wt_next = sum_wt[32] ? 32'hFFFF_FFFF : sum_wt[31:0];

  // Slot RAM write: new entry on admit, decremented remaining on a plain run.
  always_comb begin
    wr_entry  = pick.entry;
    ram_waddr = pick.idx;
    ram_we    = 1'b0;
    if (state == S_ADMIT) begin
      wr_entry.pid       = req_pid;
      wr_entry.arrival   = req_arr;
      wr_entry.burst     = req_burst;
      wr_entry.remaining = req_burst;
      ram_waddr          = free_idx;
      ram_we             = out_free && free_found;
    end else if (state == S_DONE) begin
      wr_entry.remaining = pick.entry.remaining - 16'd1;
      ram_we             = out_free && (calc_status == fps_pkg::ST_RAN);
    end
  end

  fps_ram #(
    .WIDTH (fps_pkg::ENTRY_W),
    .DEPTH (fps_pkg::SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (scan_cnt[fps_pkg::IDX_W-1:0]),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid       <= '0;
      current_time     <= '0;
      total_turnaround <= '0;
      total_waiting    <= '0;
    end else if (out_free) begin
      if ((state == S_ADMIT) && free_found) begin
        slot_valid[free_idx] <= 1'b1;
      end
      if (state == S_DONE) begin
        current_time <= current_time + 16'd1;
        if (calc_status == fps_pkg::ST_FINISHED) begin
          slot_valid[pick.idx] <= 1'b0;
          total_turnaround     <= tot_tt_next;
          total_waiting        <= tot_wt_next;
        end
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free && ((state == S_ADMIT) || (state == S_DONE))) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && (state == S_ADMIT)) begin
      status         <= free_found ? fps_pkg::ST_ADMITTED : fps_pkg::ST_FULL;
      running_id     <= '0;
      tick_time      <= current_time;
      turnaround     <= '0;
      waiting        <= '0;
      sum_turnaround <= total_turnaround;
      sum_waiting    <= total_waiting;
    end else if (out_free && (state == S_DONE)) begin
      status         <= calc_status;
      running_id     <= (calc_status == fps_pkg::ST_IDLE) ? 8'd0 : pick.entry.pid;
      tick_time      <= current_time;
      turnaround     <= calc_tt;
      waiting        <= calc_wt;
      sum_turnaround <= (calc_status == fps_pkg::ST_FINISHED) ? tot_tt_next : total_turnaround;
      sum_waiting    <= (calc_status == fps_pkg::ST_FINISHED) ? tot_wt_next : total_waiting;
    end
  end

  a_finish_frees_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free && calc_status == fps_pkg::ST_FINISHED)
      |=> !slot_valid[$past(pick.idx)])
    else $error("finished process left its slot valid");

  a_idle_means_no_pick: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && calc_status == fps_pkg::ST_IDLE) |-> !pick.found)
    else $error("idle reported while a process was picked");

  a_admit_adds_one: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADMIT && out_free && free_found)
      |=> ($countones(slot_valid) == $past($countones(slot_valid)) + 1))
    else $error("admit did not occupy exactly one slot");

  a_tick_advances_time: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (current_time == $past(current_time) + 16'd1))
    else $error("tick did not advance time by one");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for fcfs_process_scheduler: sends admit and tick words, predicts
// every report word with its own process table and checks them in order.
// Depends on fps_pkg (table size, codes) and the scheduler RTL.
`default_nettype none

module tb_top;

  localparam int NSLOT = fps_pkg::SLOTS;

  typedef struct {
    logic [2:0]    status;
    logic [7:0]    running_id;
    logic [15:0]   tick_time;
    logic [15:0]   turnaround;
    logic [15:0]   waiting;
    logic [31:0]   sum_turnaround;
    logic [31:0]   sum_waiting;
  } report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = 1'b0;
  logic [7:0]  process_id = 8'd0;
  logic [15:0] arrival = 16'd0;
  logic [15:0] burst_time = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [7:0]  running_id;
  logic [15:0] tick_time;
  logic [15:0] turnaround;
  logic [15:0] waiting;
  logic [31:0] sum_turnaround;
  logic [31:0] sum_waiting;

  // Scheduler state as the testbench sees it, advanced at each accepted word.
  logic        tbl_used    [NSLOT] = '{default: 1'b0};
  logic [7:0]  tbl_pid     [NSLOT];
  logic [15:0] tbl_arrival [NSLOT];
  logic [15:0] tbl_burst   [NSLOT];
  logic [15:0] tbl_left    [NSLOT];
  logic [15:0] clock_now = 16'd0;
  logic [31:0] acc_turnaround = 32'd0;
  logic [31:0] acc_waiting = 32'd0;

  report_t due_reports[$];
  int      mismatch_count = 0;
  bit      idling = 1'b1;
  int      hold_left = 0;

  fcfs_process_scheduler u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .process_id     (process_id),
    .arrival        (arrival),
    .burst_time     (burst_time),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .running_id     (running_id),
    .tick_time      (tick_time),
    .turnaround     (turnaround),
    .waiting        (waiting),
    .sum_turnaround (sum_turnaround),
    .sum_waiting    (sum_waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic int used_count();
    int cnt;
    cnt = 0;
    for (int i = 0; i < NSLOT; i++)
      if (tbl_used[i]) cnt++;
    return cnt;
  endfunction

  // Works out the report word for one accepted word and queues it.
  task automatic schedule_predict(input logic act, input logic [7:0] pid,
                                  input logic [15:0] arr, input logic [15:0] burst);
    report_t     rep;
    int          slot;
    logic [31:0] finish;
    logic [31:0] tt;
    logic [15:0] wt;
    rep = '{status: fps_pkg::ST_IDLE, running_id: 8'd0, tick_time: clock_now,
            turnaround: 16'd0, waiting: 16'd0, sum_turnaround: 32'd0,
            sum_waiting: 32'd0};
    slot = -1;
    if (act == fps_pkg::ACT_ADMIT) begin
      for (int i = 0; i < NSLOT; i++)
        if (!tbl_used[i] && slot < 0) slot = i;
      if (slot < 0) begin
        rep.status = fps_pkg::ST_FULL;
      end else begin
        tbl_used[slot]    = 1'b1;
        tbl_pid[slot]     = pid;
        tbl_arrival[slot] = arr;
        tbl_burst[slot]   = burst;
        tbl_left[slot]    = burst;
        rep.status = fps_pkg::ST_ADMITTED;
      end
    end else begin
      // earliest arrival among those already arrived; ties to the lower slot
      for (int i = 0; i < NSLOT; i++)
        if (tbl_used[i] && tbl_arrival[i] <= clock_now)
          if (slot < 0 || tbl_arrival[i] < tbl_arrival[slot]) slot = i;
      if (slot >= 0) begin
        rep.running_id = tbl_pid[slot];
        if (tbl_left[slot] <= 16'd1) begin
          finish = {16'd0, clock_now} + 32'd1;
          tt = finish - {16'd0, tbl_arrival[slot]};
          if (tt > 32'h0000_FFFF) tt = 32'h0000_FFFF;
          // clamp at zero when time wrapped during the run
          wt = (tt[15:0] >= tbl_burst[slot]) ? tt[15:0] - tbl_burst[slot] : 16'd0;
          acc_turnaround = sat_add(acc_turnaround, tt);
          acc_waiting    = sat_add(acc_waiting, {16'd0, wt});
          tbl_used[slot] = 1'b0;
          tbl_left[slot] = 16'd0;
          rep.status     = fps_pkg::ST_FINISHED;
          rep.turnaround = tt[15:0];
          rep.waiting    = wt;
        end else begin
          tbl_left[slot] = tbl_left[slot] - 16'd1;
          rep.status = fps_pkg::ST_RAN;
        end
      end
      clock_now = clock_now + 16'd1;
    end
    rep.sum_turnaround = acc_turnaround;
    rep.sum_waiting    = acc_waiting;
    due_reports.push_back(rep);
  endtask

  function automatic int sender_gap();
    int r;
    if (!idling) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one word and returns at the edge where it is taken. valid is left
  // high so a back-to-back word needs no second assignment in this step.
  task automatic send_word(input logic act, input logic [7:0] pid,
                           input logic [15:0] arr, input logic [15:0] burst);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    process_id   <= pid;
    arrival      <= arr;
    burst_time   <= burst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    schedule_predict(act, pid, arr, burst);
  endtask

  // Payload fields are don't-care on a tick, so they carry noise.
  task automatic send_tick();
    send_word(fps_pkg::ACT_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin : receiver
    int stall_left;
    int r;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!idling) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_stall <= 1'b0;
        end else begin
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
          out_stall <= 1'b1;
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      if (mismatch_count < 10)
        $display("mismatch on %s at %0t: expected %0d, got %0d", name, $time, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : report_check
    report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_reports.size() == 0) begin
        if (mismatch_count < 10)
          $display("report word at %0t with nothing pending, status %0d", $time, status);
        mismatch_count++;
      end else begin
        want = due_reports.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("running_id", 32'(want.running_id), 32'(running_id));
        check_field("tick_time", 32'(want.tick_time), 32'(tick_time));
        check_field("turnaround", 32'(want.turnaround), 32'(turnaround));
        check_field("waiting", 32'(want.waiting), 32'(waiting));
        check_field("sum_turnaround", want.sum_turnaround, sum_turnaround);
        check_field("sum_waiting", want.sum_waiting, sum_waiting);
      end
    end
  end

  // Idle ticks, a future arrival, zero burst, pick by earliest arrival.
  task automatic test_directed_basics();
    send_tick();
    send_word(fps_pkg::ACT_ADMIT, 8'h00, 16'd3, 16'd1);
    send_tick();
    send_word(fps_pkg::ACT_ADMIT, 8'hFF, 16'd0, 16'd0);
    send_word(fps_pkg::ACT_ADMIT, 8'h5A, 16'd1, 16'd2);
    repeat (4) send_tick();
  endtask

  // Fill every slot, then one more admit is refused. Mixed arrivals put
  // the earliest process in a higher slot, and equal arrivals test the tie.
  task automatic test_table_full();
    for (int n = 0; n <= NSLOT; n++)
      send_word(fps_pkg::ACT_ADMIT, 8'($urandom), clock_now - 16'(n % 4),
                16'($urandom_range(1, 3)));
  endtask

  // Receiver holds off while words keep coming, so the block backs up.
  task automatic test_output_backpressure();
    idling = 1'b0;
    hold_left = 300;
    for (int n = 0; n < 20; n++) begin
      if (n % 2) send_tick();
      else send_word(fps_pkg::ACT_ADMIT, 8'($urandom), clock_now, 16'd2);
    end
    idling = 1'b1;
  endtask

  task automatic test_random_traffic();
    int          r;
    int          free_slots;
    int          parked;
    int          tick_pct;
    logic [15:0] arr;
    logic [15:0] burst;
    idling = 1'b0;
    for (int n = 0; n < 2000; n++) begin
      if (n == 200) idling = 1'b1;
      free_slots = NSLOT - used_count();
      parked = 0;
      for (int i = 0; i < NSLOT; i++)
        if (tbl_used[i] && tbl_arrival[i] > clock_now) parked++;
      tick_pct = (free_slots == 0) ? 85 : (free_slots < 4) ? 65 : 45;
      if ($urandom_range(0, 99) < tick_pct) begin
        send_tick();
      end else begin
        r = $urandom_range(0, 99);
        if (r < 80) burst = 16'($urandom_range(1, 4));
        else if (r < 99) burst = 16'($urandom_range(5, 40));
        else burst = 16'($urandom_range(41, 200));
        r = $urandom_range(0, 99);
        if (r < 60)
          arr = clock_now - 16'($urandom_range(0, (clock_now < 50) ? clock_now : 50));
        else if (r < 92 || parked >= 3)
          arr = clock_now + 16'($urandom_range(1, 20));
        else
          arr = 16'($urandom);
        send_word(fps_pkg::ACT_ADMIT, 8'($urandom), arr, burst);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_basics();
    test_table_full();
    test_output_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && due_reports.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #80_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
